/* sv/dpts_pkg.sv */
// ----------------------------------------------------------------------------
// dpts_pkg : shared types and constants of the dual PID tilt servo controller
// Request payloads, sequencer states, unit opcodes and fixed-point gains.
// ----------------------------------------------------------------------------
`default_nettype none

package dpts_pkg;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] ball_x;
        logic signed [15:0] ball_y;
        logic [15:0]        step_time;
    } in_t;

    typedef struct packed {
        logic [15:0] servo_angle_0;
        logic [15:0] servo_angle_1;
        logic [15:0] servo_angle_2;
        logic        zone_x;
        logic        zone_y;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_EDT,
        ST_MUL_KP,
        ST_MUL_KI,
        ST_MUL_KD,
        ST_DIV,
        ST_MUL_S,
        ST_SERVO,
        ST_DONE
    } state_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    // Request operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_SETPOINT_X  = 3'd0;
    localparam logic [2:0] REG_SETPOINT_Y  = 3'd1;
    localparam logic [2:0] REG_INT_LIMIT   = 3'd2;
    localparam logic [2:0] REG_NEUTRAL     = 3'd3;
    localparam logic [2:0] REG_IK_GAIN     = 3'd4;
    localparam logic [2:0] REG_SERVO_MIN   = 3'd5;
    localparam logic [2:0] REG_SERVO_MAX   = 3'd6;

    // Hysteresis thresholds, Q12.4
    localparam logic [17:0] THR_CHANGE = 18'd240;
    localparam logic [17:0] THR_ENTER  = 18'd160;
    localparam logic [17:0] THR_EXIT   = 18'd320;

    // Gains, Q0.16
    localparam logic [15:0] KP_NORMAL  = 16'd5243;
    localparam logic [15:0] KD_NORMAL  = 16'd5243;
    localparam logic [15:0] KP_QUIET   = 16'd1311;
    localparam logic [15:0] KD_QUIET   = 16'd655;
    localparam logic [15:0] KI_ALL     = 16'd1966;
    localparam logic [15:0] SIN120_Q16 = 16'd56756;

    localparam int ALU_AW = 48;
    localparam int ALU_RW = 64;

endpackage

`default_nettype wire

/* sv/dual_pid_tilt_servo_controller.sv */
// ----------------------------------------------------------------------------
// dual_pid_tilt_servo_controller : two gain-scheduled PID loops and 3-servo mix
// Sequencer around one shared multiply/divide unit; fixed-point control step.
// ----------------------------------------------------------------------------
//  channel | ports                          | carries
//  --------+--------------------------------+------------------------------
//  input   | s_valid, s_ready, s_data       | operation, ball x/y, step time
//  result  | m_valid, m_ready, m_data       | three servo angles, two zones
//  config  | cfg_wr_en, cfg_index, cfg_wdata| seven control registers
//
// A control step is paced by the shared unit: twelve multiplies and up to
// two divides, each issued and handed back by the sequencer. A clear
// request completes in its accept cycle. Reset is synchronous and needs no
// clearing pass. A held result waits in the output register; the next
// request is taken while it waits, and the sequencer holds at its last
// state until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_pid_tilt_servo_controller (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire dpts_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output dpts_pkg::out_t      m_data,
    input  wire logic           cfg_wr_en,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_wdata
);
    import dpts_pkg::*;

    state_t             state_reg, state_next;
    logic               run_reg, run_next;
    logic               sel_reg, sel_next;
    logic [1:0]         idx_reg, idx_next;

    logic signed [15:0] sp_x_reg, sp_y_reg;
    logic [14:0]        ilim_reg;
    logic [15:0]        neutral_reg, ik_reg, smin_reg, smax_reg;

    logic signed [15:0] bx_reg, bx_next, by_reg, by_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [39:0] integ_x_reg, integ_x_next, integ_y_reg, integ_y_next;
    logic signed [16:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic               quiet_x_reg, quiet_x_next, quiet_y_reg, quiet_y_next;
    logic signed [16:0] e_reg, e_next;
    logic signed [17:0] diff_reg, diff_next;
    logic signed [47:0] u_reg, u_next;
    logic signed [47:0] num_reg, num_next;
    logic signed [39:0] p_reg, p_next, r_reg, r_next, sr_reg, sr_next;
    logic [15:0]        ang_reg [3];
    logic [15:0]        ang_next [3];
    logic               m_valid_reg, m_valid_next;
    out_t               out_reg, out_next;

    logic               alu_start;
    alu_op_t            alu_op;
    logic signed [47:0] alu_a;
    logic [15:0]        alu_b;
    logic signed [63:0] alu_res;
    logic               alu_done;

    logic               accept;
    logic               loop_end;
    logic               quiet_sel;
    logic signed [39:0] integ_sel;
    logic signed [16:0] last_sel;
    logic signed [16:0] e_new;
    logic signed [17:0] diff_new;
    logic [17:0]        d_abs, e_abs;
    logic               q_tmp;
    logic signed [40:0] isum, ilim;
    logic signed [63:0] res_sh16;
    logic signed [47:0] u_fin;
    logic signed [47:0] u_fin_sh;
    logic signed [39:0] hp;
    logic signed [40:0] mix;
    logic signed [41:0] ang;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign quiet_sel = sel_reg ? quiet_y_reg : quiet_x_reg;
    assign integ_sel = sel_reg ? integ_y_reg : integ_x_reg;
    assign last_sel  = sel_reg ? last_y_reg : last_x_reg;
    assign res_sh16  = alu_res >>> 16;
    assign loop_end  = ((state_reg == ST_MUL_KD) && run_reg && alu_done && (dt_reg == '0))
                    || ((state_reg == ST_DIV) && run_reg && alu_done);

    dpts_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .op      (alu_op),
        .a       (alu_a),
        .b       (alu_b),
        .res     (alu_res),
        .done    (alu_done)
    );

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.operation == OP_STEP) state_next = ST_PREP;
            end
            ST_PREP: state_next = ST_MUL_EDT;
            ST_MUL_EDT: if (run_reg && alu_done) state_next = ST_MUL_KP;
            ST_MUL_KP:  if (run_reg && alu_done) state_next = ST_MUL_KI;
            ST_MUL_KI:  if (run_reg && alu_done) state_next = ST_MUL_KD;
            ST_MUL_KD: begin
                if (run_reg && alu_done) begin
                    if (dt_reg != '0)  state_next = ST_DIV;
                    else if (!sel_reg) state_next = ST_PREP;
                    else               state_next = ST_MUL_S;
                end
            end
            ST_DIV: begin
                if (run_reg && alu_done) state_next = sel_reg ? ST_MUL_S : ST_PREP;
            end
            ST_MUL_S:  if (run_reg && alu_done) state_next = ST_SERVO;
            ST_SERVO: begin
                if (run_reg && alu_done && idx_reg == 2'd2) state_next = ST_DONE;
            end
            ST_DONE: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Drive the shared unit and update the datapath
    always_comb begin
        run_next     = run_reg;
        sel_next     = sel_reg;
        idx_next     = idx_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        dt_next      = dt_reg;
        integ_x_next = integ_x_reg;
        integ_y_next = integ_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        quiet_x_next = quiet_x_reg;
        quiet_y_next = quiet_y_reg;
        e_next       = e_reg;
        diff_next    = diff_reg;
        u_next       = u_reg;
        num_next     = num_reg;
        p_next       = p_reg;
        r_next       = r_reg;
        sr_next      = sr_reg;
        ang_next     = ang_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        alu_start    = 1'b0;
        alu_op       = ALU_MUL;
        alu_a        = '0;
        alu_b        = '0;
        e_new        = sel_reg ? 17'(sp_y_reg) - 17'(by_reg) : 17'(sp_x_reg) - 17'(bx_reg);
        diff_new     = 18'(e_new) - 18'(last_sel);
        d_abs        = diff_new[17] ? 18'(-diff_new) : 18'(diff_new);
        e_abs        = e_new[16] ? 18'(-19'(e_new)) : 18'(e_new);
        q_tmp        = quiet_sel;
        isum         = 41'(integ_sel) + 41'(alu_res[40:0]);
        ilim         = $signed({10'b0, ilim_reg, 16'b0});
        u_fin        = u_reg + ((state_reg == ST_DIV) ? alu_res[47:0] : 48'(0));
        u_fin_sh     = u_fin >>> 8;
        hp           = 40'((-41'(p_reg)) >>> 1);
        mix          = (idx_reg == 2'd0) ? 41'(p_reg)
                     : (idx_reg == 2'd1) ? 41'(hp) + 41'(sr_reg)
                     : 41'(hp) - 41'(sr_reg);
        ang          = $signed({26'b0, neutral_reg}) + res_sh16[41:0];

        // Issue the unit once per arithmetic state, and once per servo in the servo state
        if (state_reg != ST_IDLE && state_reg != ST_PREP && state_reg != ST_DONE) begin
            if (!run_reg) begin
                alu_start = 1'b1;
                run_next  = 1'b1;
            end else if (alu_done) begin
                run_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == OP_CLEAR) begin
                        integ_x_next = '0;
                        integ_y_next = '0;
                        last_x_next  = '0;
                        last_y_next  = '0;
                    end else begin
                        bx_next  = s_data.ball_x;
                        by_next  = s_data.ball_y;
                        dt_next  = s_data.step_time;
                        sel_next = 1'b0;
                    end
                end
            end
            ST_PREP: begin
                // Zone hysteresis on error size and change
                if (q_tmp && (d_abs > THR_CHANGE || e_abs > THR_EXIT)) q_tmp = 1'b0;
                if (!q_tmp && d_abs <= THR_CHANGE && e_abs <= THR_ENTER) q_tmp = 1'b1;
                if (sel_reg) quiet_y_next = q_tmp;
                else         quiet_x_next = q_tmp;
                e_next    = e_new;
                diff_next = diff_new;
            end
            ST_MUL_EDT: begin
                alu_a = 48'(e_reg);
                alu_b = dt_reg;
                if (run_reg && alu_done) begin
                    if (isum > ilim)       isum = ilim;
                    else if (isum < -ilim) isum = -ilim;
                    if (sel_reg) integ_y_next = isum[39:0];
                    else         integ_x_next = isum[39:0];
                end
            end
            ST_MUL_KP: begin
                alu_a = 48'(e_reg);
                alu_b = quiet_sel ? KP_QUIET : KP_NORMAL;
                if (run_reg && alu_done) u_next = alu_res[47:0];
            end
            ST_MUL_KI: begin
                alu_a = 48'(integ_sel);
                alu_b = KI_ALL;
                if (run_reg && alu_done) u_next = u_reg + res_sh16[47:0];
            end
            ST_MUL_KD: begin
                alu_a = 48'(diff_reg);
                alu_b = quiet_sel ? KD_QUIET : KD_NORMAL;
                if (run_reg && alu_done) num_next = {alu_res[31:0], 16'b0};
            end
            ST_DIV: begin
                alu_op = ALU_DIV;
                alu_a  = num_reg;
                alu_b  = dt_reg;
            end
            ST_MUL_S: begin
                alu_a = 48'(r_reg);
                alu_b = SIN120_Q16;
                if (run_reg && alu_done) begin
                    sr_next  = res_sh16[39:0];
                    idx_next = 2'd0;
                end
            end
            ST_SERVO: begin
                alu_a = 48'(mix);
                alu_b = ik_reg;
                if (run_reg && alu_done) begin
                    if (ang < $signed({26'b0, smin_reg})) ang = $signed({26'b0, smin_reg});
                    if (ang > $signed({26'b0, smax_reg})) ang = $signed({26'b0, smax_reg});
                    ang_next[idx_reg] = ang[15:0];
                    idx_next          = idx_reg + 2'd1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    out_next.servo_angle_0 = ang_reg[0];
                    out_next.servo_angle_1 = ang_reg[1];
                    out_next.servo_angle_2 = ang_reg[2];
                    out_next.zone_x        = quiet_x_reg;
                    out_next.zone_y        = quiet_y_reg;
                end
            end
            default: ;
        endcase

        // Close a loop: keep the output term and the error
        if (loop_end) begin
            u_next = u_fin;
            if (sel_reg) begin
                r_next      = u_fin_sh[39:0];
                last_y_next = e_reg;
            end else begin
                p_next      = u_fin_sh[39:0];
                last_x_next = e_reg;
                sel_next    = 1'b1;
            end
        end
    end

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_x_reg    <= '0;
            sp_y_reg    <= '0;
            ilim_reg    <= 15'd800;
            neutral_reg <= 16'd24320;
            ik_reg      <= 16'd4096;
            smin_reg    <= 16'd0;
            smax_reg    <= 16'd46080;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SETPOINT_X: sp_x_reg    <= $signed(cfg_wdata);
                REG_SETPOINT_Y: sp_y_reg    <= $signed(cfg_wdata);
                REG_INT_LIMIT:  ilim_reg    <= cfg_wdata[14:0];
                REG_NEUTRAL:    neutral_reg <= cfg_wdata;
                REG_IK_GAIN:    ik_reg      <= cfg_wdata;
                REG_SERVO_MIN:  smin_reg    <= cfg_wdata;
                REG_SERVO_MAX:  smax_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            integ_x_reg <= '0;
            integ_y_reg <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            quiet_x_reg <= 1'b0;
            quiet_y_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
            integ_x_reg <= integ_x_next;
            integ_y_reg <= integ_y_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            quiet_x_reg <= quiet_x_next;
            quiet_y_reg <= quiet_y_next;
        end
        sel_reg  <= sel_next;
        idx_reg  <= idx_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        dt_reg   <= dt_next;
        e_reg    <= e_next;
        diff_reg <= diff_next;
        u_reg    <= u_next;
        num_reg  <= num_next;
        p_reg    <= p_next;
        r_reg    <= r_next;
        sr_reg   <= sr_next;
        ang_reg  <= ang_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

/* sv/dpts_alu.sv */
// ----------------------------------------------------------------------------
// dpts_alu : shared shift-add multiplier and restoring divider
// Signed 48-bit operand times unsigned 16-bit operand, or signed 48-bit
// dividend over unsigned 16-bit divisor, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module dpts_alu (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire dpts_pkg::alu_op_t                 op,
    input  wire logic signed [dpts_pkg::ALU_AW-1:0] a,
    input  wire logic [15:0]                       b,
    output logic signed [dpts_pkg::ALU_RW-1:0]      res,
    output logic                                   done
);
    import dpts_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    alu_op_t          op_reg, op_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      mc_reg, mc_next;
    logic [15:0]      mb_reg, mb_next;
    logic [15:0]      rem_reg, rem_next;
    logic             neg_reg, neg_next;

    logic [47:0]      a_mag;
    logic [16:0]      rem_sh;
    logic [47:0]      quo_s;

    // Step the shared adder: accumulate for multiply, trial subtract for divide
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mb_next   = mb_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        a_mag     = a[47] ? 48'(-a) : 48'(a);
        rem_sh    = {rem_reg, acc_reg[47]};
        if (start) begin
            busy_next = 1'b1;
            op_next   = op;
            mb_next   = b;
            rem_next  = '0;
            neg_next  = a[47];
            mc_next   = 64'(a);
            if (op == ALU_MUL) begin
                acc_next = '0;
                cnt_next = 6'd15;
            end else begin
                acc_next = {16'b0, a_mag};
                cnt_next = 6'd47;
            end
        end else if (busy_reg) begin
            if (op_reg == ALU_MUL) begin
                if (mb_reg[0]) begin
                    acc_next = acc_reg + mc_reg;
                end
                mc_next = {mc_reg[62:0], 1'b0};
                mb_next = {1'b0, mb_reg[15:1]};
            end else begin
                if (rem_sh >= {1'b0, mb_reg}) begin
                    rem_next = 16'(rem_sh - {1'b0, mb_reg});
                    acc_next = {16'b0, acc_reg[46:0], 1'b1};
                end else begin
                    rem_next = rem_sh[15:0];
                    acc_next = {16'b0, acc_reg[46:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mb_reg  <= mb_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // Apply the dividend sign to the quotient
    assign quo_s = neg_reg ? 48'(-acc_reg[47:0]) : acc_reg[47:0];
    assign res   = (op_reg == ALU_MUL) ? $signed(acc_reg)
                                       : $signed({{16{quo_s[47]}}, quo_s});
    assign done  = done_reg;

endmodule

`default_nettype wire

/* sv/dpts_checker.sv */
// ----------------------------------------------------------------------------
// dpts_checker : port-level checks for the dual PID tilt servo controller
// Watches the request and result channels and binds to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpts_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire dpts_pkg::in_t  s_data,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire dpts_pkg::out_t m_data
);
    import dpts_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset drops the result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A control step keeps the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == OP_STEP |=> !s_ready)
        else $error("ready while a step is in progress");

    // A new result appears only at the end of a step
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a step");

endmodule

bind dual_pid_tilt_servo_controller dpts_checker u_dpts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
